@@ design/tkpt_pkg.sv @@
`default_nettype none

package tkpt_pkg;

    // field widths
    localparam int CNT_W      = 8;
    localparam int POS_W      = 13;
    localparam int ROT_W      = 12;
    localparam int LO_W       = 12;
    localparam int BND_W      = 13;
    localparam int DET_W      = POS_W - 2;
    localparam int SAMPLE_W   = 32;
    localparam int BTN_W      = 3;

    // sample layout
    localparam int RED_LSB    = 16;
    localparam int GRN_LSB    = 8;
    localparam int BLU_LSB    = 0;
    localparam int BTN_LSB    = 24;

    // result layout, lowest field first
    localparam int BLU_OFS      = 2 * POS_W;
    localparam int DET_OFS      = 3 * POS_W;
    localparam int OUT_FIELDS_W = 3 * POS_W + DET_W + 4;
    localparam int OUT_W        = ((OUT_FIELDS_W + 7) / 8) * 8;

    // config port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    // pipeline depth of the red delta remainder (one bit per stage + fixup)
    localparam int MOD_STAGES = CNT_W + 1;
    // bit counter of the red residue recompute unit
    localparam int NCNT_W     = $clog2(POS_W + 1);

    localparam logic [ROT_W-1:0]        ROT_RESET  = ROT_W'(256);
    localparam logic signed [BND_W-1:0] BMAX_RESET = BND_W'(255);
    localparam logic signed [POS_W:0]   POS_MAX_X  = (POS_W + 1)'((1 << (POS_W - 1)) - 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NEGATE,
        CFG_ROTATION,
        CFG_LOWER,
        CFG_BLUE_MIN,
        CFG_BLUE_MAX
    } t_cfg_idx;

    typedef logic signed [CNT_W:0] t_delta;

    typedef struct packed {
        t_delta           d_green;
        t_delta           d_blue;
        logic [BTN_W-1:0] rise;     // [2] red, [1] green, [0] blue
        logic             all_rise;
    } t_side;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [ROT_W-1:0] rel;
    } t_norm;

    // one restoring remainder step: shift in a bit, subtract divisor if it fits
    function automatic logic [ROT_W-1:0] f_mod_step(
        input logic [ROT_W-1:0] rem,
        input logic             bit_in,
        input logic [ROT_W-1:0] rot
    );
        logic [ROT_W:0] t;
        logic [ROT_W:0] d;
        t = {rem, bit_in};
        d = t - {1'b0, rot};
        if (t >= {1'b0, rot}) begin
            f_mod_step = d[ROT_W-1:0];
        end else begin
            f_mod_step = t[ROT_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

@@ design/triple_knob_position_tracker.sv @@
// Registers: lane delta, remainder stages, remainder fixup, merge output.
// Throughput: one beat per cycle unless output stalls or config work holds input;
// the red lane's remainder pipeline sets the depth. A config write stalls input
// while red's residue is recomputed one bit per cycle; config is taken every cycle.
// Reset: i_rst_n synchronous, active low; clears positions, previous counts,
// previous buttons, the first-sample flag and all config registers to defaults.
`default_nettype none

module triple_knob_position_tracker import tkpt_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [SAMPLE_W-1:0]   s_axis_tdata,   // [31:0] raw_sample
    // result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_W-1:0]      m_axis_tdata,   // [12:0] red_position,
                                                  // [25:13] green_position,
                                                  // [38:26] blue_position,
                                                  // [49:39] blue_detent,
                                                  // [50] red_rise, [51] green_rise,
                                                  // [52] blue_rise, [53] all_rise,
                                                  // [55:54] zero
    // config write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // config registers
    logic                    r_negate;
    logic [ROT_W-1:0]        r_rot;
    logic signed [LO_W-1:0]  r_lo;
    logic signed [BND_W-1:0] r_bmin;
    logic signed [BND_W-1:0] r_bmax;

    // sample history
    logic                    r_primed;
    logic [BTN_W-1:0]        r_prev_btn;

    // stage 0 button flags
    logic [BTN_W-1:0]        r_rise;
    logic                    r_all;

    // valid line: stage 0 (lanes) through the last remainder stage
    logic [MOD_STAGES:0]     r_vld;
    t_side                   r_side [1:MOD_STAGES];

    logic                    w_adv;
    logic                    w_accept;
    logic                    w_cfg_we;
    logic [BTN_W-1:0]        w_btn;
    t_delta                  w_d_red;
    t_delta                  w_d_grn;
    t_delta                  w_d_blu;
    logic [ROT_W-1:0]        w_dm;
    t_norm                   w_norm;
    logic signed [POS_W-1:0] w_red_pos;

    // whole pipe moves together; output register frees a slot when taken
    assign w_adv         = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_adv && !w_norm.busy && !i_cfg_valid;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign w_cfg_we      = i_cfg_valid && o_cfg_ready;
    assign w_btn         = s_axis_tdata[BTN_LSB +: BTN_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_negate <= 1'b0;
            r_rot    <= ROT_RESET;
            r_lo     <= '0;
            r_bmin   <= '0;
            r_bmax   <= BMAX_RESET;
        end else if (w_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_NEGATE:   r_negate <= i_cfg_data[0];
                CFG_ROTATION: r_rot    <= i_cfg_data[ROT_W-1:0];
                CFG_LOWER:    r_lo     <= i_cfg_data[LO_W-1:0];
                CFG_BLUE_MIN: r_bmin   <= i_cfg_data[BND_W-1:0];
                CFG_BLUE_MAX: r_bmax   <= i_cfg_data[BND_W-1:0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_primed   <= 1'b0;
            r_prev_btn <= '0;
            r_vld      <= '0;
        end else begin
            if (w_accept) begin
                r_primed   <= 1'b1;
                r_prev_btn <= w_btn;
            end
            if (w_adv) begin
                r_vld <= {r_vld[MOD_STAGES-1:0], w_accept};
            end
        end
    end

    // edge flags ride along with the beat
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rise <= w_btn & ~r_prev_btn;
            r_all  <= (w_btn == '1) && (r_prev_btn != '1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_side[1] <= '{d_green: w_d_grn, d_blue: w_d_blu, rise: r_rise, all_rise: r_all};
            for (int j = 2; j <= MOD_STAGES; j++) begin
                r_side[j] <= r_side[j-1];
            end
        end
    end

    // per-channel delta lanes
    tkpt_lane u_lane_red (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_accept),
        .i_primed (r_primed),
        .i_negate (r_negate),
        .i_count  (s_axis_tdata[RED_LSB +: CNT_W]),
        .o_delta  (w_d_red)
    );

    tkpt_lane u_lane_grn (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_accept),
        .i_primed (r_primed),
        .i_negate (r_negate),
        .i_count  (s_axis_tdata[GRN_LSB +: CNT_W]),
        .o_delta  (w_d_grn)
    );

    tkpt_lane u_lane_blu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_accept),
        .i_primed (r_primed),
        .i_negate (r_negate),
        .i_count  (s_axis_tdata[BLU_LSB +: CNT_W]),
        .o_delta  (w_d_blu)
    );

    // red delta reduced mod rotation so the wrap is one compare-subtract
    tkpt_mod_pipe u_mod (
        .i_clk   (i_clk),
        .i_adv   (w_adv),
        .i_delta (w_d_red),
        .i_rot   (r_rot),
        .o_dm    (w_dm)
    );

    // red offset recompute after any config write
    tkpt_red_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_cfg_we),
        .i_pos   (w_red_pos),
        .i_lo    (r_lo),
        .i_rot   (r_rot),
        .o_norm  (w_norm)
    );

    tkpt_merge u_merge (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (w_adv),
        .i_valid   (r_vld[MOD_STAGES]),
        .i_dm      (w_dm),
        .i_side    (r_side[MOD_STAGES]),
        .i_rot     (r_rot),
        .i_lo      (r_lo),
        .i_bmin    (r_bmin),
        .i_bmax    (r_bmax),
        .i_norm    (w_norm),
        .o_valid   (m_axis_tvalid),
        .o_data    (m_axis_tdata),
        .o_red_pos (w_red_pos)
    );

endmodule

`default_nettype wire

@@ design/tkpt_lane.sv @@
`default_nettype none

// One knob channel: modular count delta against the previous sample.
module tkpt_lane import tkpt_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  logic             i_primed,
    input  logic             i_negate,
    input  logic [CNT_W-1:0] i_count,
    output t_delta           o_delta
);

    logic [CNT_W-1:0] r_prev;
    t_delta           r_delta;
    logic [CNT_W-1:0] w_diff;
    t_delta           w_ext;
    t_delta           n_delta;

    always_comb begin
        w_diff = i_count - r_prev;
        w_ext  = {w_diff[CNT_W-1], w_diff};
        if (!i_primed) begin
            n_delta = '0;
        end else if (i_negate) begin
            n_delta = -w_ext;
        end else begin
            n_delta = w_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
        end else if (i_load) begin
            r_prev <= i_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_delta <= n_delta;
        end
    end

    assign o_delta = r_delta;

endmodule

`default_nettype wire

@@ design/tkpt_mod_pipe.sv @@
`default_nettype none

// Pipelined remainder of the red delta by the rotation span, one bit per stage.
// Output is in [0, rot); meaningless when rot is zero (merge overrides).
module tkpt_mod_pipe import tkpt_pkg::*; (
    input  logic             i_clk,
    input  logic             i_adv,
    input  t_delta           i_delta,
    input  logic [ROT_W-1:0] i_rot,
    output logic [ROT_W-1:0] o_dm
);

    logic [ROT_W-1:0] r_rem [CNT_W];
    logic [CNT_W-1:0] r_mag [CNT_W];
    logic             r_neg [CNT_W];
    logic [ROT_W-1:0] r_dm;

    t_delta           w_abs;
    logic [CNT_W-1:0] w_mag;
    logic [ROT_W-1:0] n_dm;

    always_comb begin
        w_abs = i_delta[CNT_W] ? -i_delta : i_delta;
        w_mag = w_abs[CNT_W-1:0];
        if (r_neg[CNT_W-1] && (r_rem[CNT_W-1] != '0)) begin
            n_dm = i_rot - r_rem[CNT_W-1];
        end else begin
            n_dm = r_rem[CNT_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_rem[0] <= f_mod_step('0, w_mag[CNT_W-1], i_rot);
            r_mag[0] <= w_mag;
            r_neg[0] <= i_delta[CNT_W];
            r_dm     <= n_dm;
        end
    end

    for (genvar j = 1; j < CNT_W; j++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_rem[j] <= f_mod_step(r_rem[j-1], r_mag[j-1][CNT_W-1-j], i_rot);
                r_mag[j] <= r_mag[j-1];
                r_neg[j] <= r_neg[j-1];
            end
        end
    end

    assign o_dm = r_dm;

endmodule

`default_nettype wire

@@ design/tkpt_red_norm.sv @@
`default_nettype none

// Bit-serial recompute of (red_pos - lower) mod rotation after a config write.
module tkpt_red_norm import tkpt_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [POS_W-1:0] i_pos,
    input  logic signed [LO_W-1:0]  i_lo,
    input  logic [ROT_W-1:0]        i_rot,
    output t_norm                   o_norm
);

    logic              r_load;
    logic              r_busy;
    logic [NCNT_W-1:0] r_cnt;
    logic [POS_W-1:0]  r_mag;
    logic [ROT_W-1:0]  r_rem;
    logic              r_neg;

    logic signed [POS_W:0] w_x;
    logic signed [POS_W:0] w_abs;
    logic [ROT_W-1:0]      w_rel;

    always_comb begin
        w_x   = {i_pos[POS_W-1], i_pos} - {{(POS_W + 1 - LO_W){i_lo[LO_W-1]}}, i_lo};
        w_abs = w_x[POS_W] ? -w_x : w_x;
        if (i_rot == '0) begin
            w_rel = '0;
        end else if (r_neg && (r_rem != '0)) begin
            w_rel = i_rot - r_rem;
        end else begin
            w_rel = r_rem;
        end
        o_norm.busy = r_busy;
        o_norm.done = r_busy && !r_load && (r_cnt == '0);
        o_norm.rel  = w_rel;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load <= 1'b0;
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_load <= 1'b1;
            r_busy <= 1'b1;
        end else if (r_load) begin
            r_load <= 1'b0;
            r_cnt  <= NCNT_W'(POS_W);
        end else if (r_cnt != '0) begin
            r_cnt  <= r_cnt - 1'b1;
        end else if (r_busy) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_load) begin
            r_mag <= w_abs[POS_W-1:0];
            r_neg <= w_x[POS_W];
            r_rem <= '0;
        end else if (r_cnt != '0) begin
            r_mag <= {r_mag[POS_W-2:0], 1'b0};
            r_rem <= f_mod_step(r_rem, r_mag[POS_W-1], i_rot);
        end
    end

endmodule

`default_nettype wire

@@ design/tkpt_merge.sv @@
`default_nettype none

// Merge stage: applies lane deltas to the positions, clamps, packs the result.
module tkpt_merge import tkpt_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_adv,
    input  logic                    i_valid,
    input  logic [ROT_W-1:0]        i_dm,
    input  t_side                   i_side,
    input  logic [ROT_W-1:0]        i_rot,
    input  logic signed [LO_W-1:0]  i_lo,
    input  logic signed [BND_W-1:0] i_bmin,
    input  logic signed [BND_W-1:0] i_bmax,
    input  t_norm                   i_norm,
    output logic                    o_valid,
    output logic [OUT_W-1:0]        o_data,
    output logic signed [POS_W-1:0] o_red_pos
);

    // red kept as offset above lower bound, in [0, rot); zero if rot is zero
    logic [ROT_W-1:0]        r_red_rel;
    logic signed [POS_W-1:0] r_red_pos;
    logic signed [POS_W-1:0] r_grn_pos;
    logic signed [POS_W-1:0] r_blu_pos;
    logic                    r_valid;
    logic [OUT_W-1:0]        r_data;

    logic signed [POS_W:0]   w_lo_x;
    logic signed [POS_W:0]   w_rot_x;
    logic signed [POS_W:0]   w_bmin_x;
    logic signed [POS_W:0]   w_bmax_x;
    logic [ROT_W:0]          w_s;
    logic [ROT_W:0]          w_s_sub;
    logic [ROT_W-1:0]        w_s2;
    logic signed [POS_W:0]   w_red_sum;
    logic signed [POS_W:0]   w_hi;
    logic signed [POS_W-1:0] n_red_pos;
    logic [ROT_W-1:0]        n_red_rel;
    logic signed [POS_W:0]   w_g;
    logic signed [POS_W:0]   w_b;
    logic signed [POS_W:0]   w_g_c;
    logic signed [POS_W:0]   w_b_c;
    logic signed [POS_W-1:0] n_grn_pos;
    logic signed [POS_W-1:0] n_blu_pos;
    logic signed [POS_W:0]   w_bq;
    logic signed [POS_W:0]   w_bsh;
    logic [DET_W-1:0]        w_det;

    always_comb begin
        w_lo_x   = {{(POS_W + 1 - LO_W){i_lo[LO_W-1]}}, i_lo};
        w_rot_x  = {{(POS_W + 1 - ROT_W){1'b0}}, i_rot};
        w_bmin_x = {{(POS_W + 1 - BND_W){i_bmin[BND_W-1]}}, i_bmin};
        w_bmax_x = {{(POS_W + 1 - BND_W){i_bmax[BND_W-1]}}, i_bmax};

        // red: modular add, then top saturation of lower + offset
        w_s     = {1'b0, r_red_rel} + {1'b0, i_dm};
        w_s_sub = w_s - {1'b0, i_rot};
        if (i_rot == '0) begin
            w_s2 = '0;
        end else if (w_s >= {1'b0, i_rot}) begin
            w_s2 = w_s_sub[ROT_W-1:0];
        end else begin
            w_s2 = w_s[ROT_W-1:0];
        end
        w_red_sum = w_lo_x + {{(POS_W + 1 - ROT_W){1'b0}}, w_s2};
        w_hi      = POS_MAX_X - w_lo_x;
        if (w_red_sum > POS_MAX_X) begin
            n_red_pos = POS_MAX_X[POS_W-1:0];
            n_red_rel = w_hi[ROT_W-1:0];
        end else begin
            n_red_pos = w_red_sum[POS_W-1:0];
            n_red_rel = w_s2;
        end

        // green: upper bound wins
        w_g = {r_grn_pos[POS_W-1], r_grn_pos}
            + {{(POS_W - CNT_W){i_side.d_green[CNT_W]}}, i_side.d_green};
        if (w_g > w_rot_x) begin
            w_g_c = w_rot_x;
        end else if (w_g < w_lo_x) begin
            w_g_c = w_lo_x;
        end else begin
            w_g_c = w_g;
        end
        n_grn_pos = w_g_c[POS_W-1:0];

        // blue: max bound wins, inclusive
        w_b = {r_blu_pos[POS_W-1], r_blu_pos}
            + {{(POS_W - CNT_W){i_side.d_blue[CNT_W]}}, i_side.d_blue};
        if (w_b >= w_bmax_x) begin
            w_b_c = w_bmax_x;
        end else if (w_b < w_bmin_x) begin
            w_b_c = w_bmin_x;
        end else begin
            w_b_c = w_b;
        end
        n_blu_pos = w_b_c[POS_W-1:0];

        // divide by four toward zero
        w_bq  = w_b_c + {{(POS_W - 1){1'b0}}, w_b_c[POS_W], w_b_c[POS_W]};
        w_bsh = w_bq >>> 2;
        w_det = w_bsh[DET_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_red_rel <= '0;
            r_red_pos <= '0;
            r_grn_pos <= '0;
            r_blu_pos <= '0;
            r_valid   <= 1'b0;
        end else begin
            if (i_adv) begin
                r_valid <= i_valid;
            end
            if (i_adv && i_valid) begin
                r_red_rel <= n_red_rel;
                r_red_pos <= n_red_pos;
                r_grn_pos <= n_grn_pos;
                r_blu_pos <= n_blu_pos;
            end else if (i_norm.done) begin
                r_red_rel <= i_norm.rel;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && i_valid) begin
            r_data <= {{(OUT_W - OUT_FIELDS_W){1'b0}},
                       i_side.all_rise, i_side.rise[0], i_side.rise[1], i_side.rise[2],
                       w_det, n_blu_pos, n_grn_pos, n_red_pos};
        end
    end

    assign o_valid   = r_valid;
    assign o_data    = r_data;
    assign o_red_pos = r_red_pos;

endmodule

`default_nettype wire

@@ design/tkpt_checker.sv @@
`default_nettype none

module tkpt_checker import tkpt_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tready,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [OUT_W-1:0]      m_axis_tdata,
    input  logic                  i_cfg_valid,
    input  logic                  o_cfg_ready
);

    logic signed [POS_W:0] w_blue;
    logic signed [POS_W:0] w_bq;
    logic signed [POS_W:0] w_bsh;
    logic [DET_W-1:0]      w_det_exp;

    always_comb begin
        w_blue    = {m_axis_tdata[BLU_OFS + POS_W - 1], m_axis_tdata[BLU_OFS +: POS_W]};
        w_bq      = w_blue + {{(POS_W - 1){1'b0}}, w_blue[POS_W], w_blue[POS_W]};
        w_bsh     = w_bq >>> 2;
        w_det_exp = w_bsh[DET_W-1:0];
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    a_cfg_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> !s_axis_tready)
        else $error("input ready during config write");

    a_cfg_then_recompute: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && o_cfg_ready |=> !s_axis_tready)
        else $error("input ready right after config write");

    a_detent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[DET_OFS +: DET_W] == w_det_exp)
        else $error("blue detent does not match blue position");

endmodule

bind triple_knob_position_tracker tkpt_checker u_tkpt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .i_cfg_valid   (i_cfg_valid),
    .o_cfg_ready   (o_cfg_ready)
);

`default_nettype wire

@@ tb/tb_top.sv @@
`default_nettype none

module tb_top;
    import tkpt_pkg::*;

    // Run limits. The slowest legal run is roughly 1250 beats, each with the
    // longest send gap and receive stall and a trip through the pipe, plus
    // the config stalls.
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = MOD_STAGES + 8;   // outlasts a beat's trip through the pipe
    localparam int REPORT_MAX   = 10;
    localparam int PHASES       = 12;
    localparam int PHASE_BEATS  = 100;
    localparam int SPARE_IDX    = int'(CFG_BLUE_MAX) + 1;  // first unused register slot
    localparam logic [BTN_W-1:0] ALL_DOWN = '1;

    // Result word as the block packs it, lowest field last in the list.
    typedef struct packed {
        logic [OUT_W-OUT_FIELDS_W-1:0] pad;
        logic                          all_rise;
        logic                          blue_rise;
        logic                          green_rise;
        logic                          red_rise;
        logic signed [DET_W-1:0]       detent;
        logic signed [POS_W-1:0]       blue;
        logic signed [POS_W-1:0]       green;
        logic signed [POS_W-1:0]       red;
    } t_knob_result;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [SAMPLE_W-1:0]   s_axis_tdata;    // [31:0] raw_sample
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_W-1:0]      m_axis_tdata;    // red, green, blue, detent, rises, pad
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    triple_knob_position_tracker DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // ------------------------------------------------------------------
    // Tracker model: its own copy of config and knob state
    // ------------------------------------------------------------------
    logic              trk_negate   = 1'b0;
    logic [ROT_W-1:0]  trk_rotation = ROT_RESET;
    logic [LO_W-1:0]   trk_lower    = '0;
    logic [BND_W-1:0]  trk_blue_min = '0;
    logic [BND_W-1:0]  trk_blue_max = BMAX_RESET;

    logic [CNT_W-1:0]  trk_count [3] = '{default: '0};
    int                trk_pos   [3] = '{default: 0};
    logic [BTN_W-1:0]  trk_buttons   = '0;
    bit                trk_primed    = 1'b0;

    t_knob_result      predicted_readings [$];
    int                mismatch_count = 0;
    int                cycle_count    = 0;
    bit                idle_on        = 1'b1;

    // last counts and buttons sent, so well-formed turns build on them
    logic [CNT_W-1:0]  sent_count [3] = '{default: '0};
    logic [BTN_W-1:0]  sent_buttons   = '0;

    // lane 0 red, 1 green, 2 blue
    function automatic int lane_lsb(input int k);
        return (k == 0) ? RED_LSB : (k == 1) ? GRN_LSB : BLU_LSB;
    endfunction

    function automatic int clamp_pos(input int v);
        int hi;
        hi = (1 << (POS_W - 1)) - 1;
        if (v > hi) return hi;
        if (v < -hi - 1) return -hi - 1;
        return v;
    endfunction

    function automatic t_knob_result track_sample(input logic [SAMPLE_W-1:0] w);
        t_knob_result     r;
        logic [BTN_W-1:0] btn;
        logic [BTN_W-1:0] rise;
        logic [CNT_W-1:0] now;
        logic [CNT_W-1:0] diff;
        int               d;
        int               v;
        int               rem;
        int               rot;
        int               lo;
        int               bmin;
        int               bmax;
        btn  = w[BTN_LSB +: BTN_W];
        rot  = int'(trk_rotation);
        lo   = int'($signed(trk_lower));
        bmin = int'($signed(trk_blue_min));
        bmax = int'($signed(trk_blue_max));
        for (int k = 0; k < 3; k++) begin
            now = w[lane_lsb(k) +: CNT_W];
            d = 0;
            if (trk_primed) begin
                diff = now - trk_count[k];      // modular change of the count
                d = int'($signed(diff));
                if (trk_negate) d = -d;
            end
            trk_pos[k] += d;
            trk_count[k] = now;
        end
        trk_primed = 1'b1;

        // red wraps into [lo, lo + rot); zero span pins it to lo
        if (rot == 0) begin
            v = lo;
        end else begin
            rem = (trk_pos[0] - lo) % rot;
            if (rem < 0) rem += rot;
            v = lo + rem;
        end
        trk_pos[0] = clamp_pos(v);

        // green: upper bound wins when the bounds cross
        v = trk_pos[1];
        if (v > rot) v = rot;
        else if (v < lo) v = lo;
        trk_pos[1] = clamp_pos(v);

        // blue: max wins when the bounds cross
        v = trk_pos[2];
        if (v >= bmax) v = bmax;
        else if (v < bmin) v = bmin;
        trk_pos[2] = clamp_pos(v);

        rise = btn & ~trk_buttons;
        r.pad        = '0;
        r.red        = POS_W'(trk_pos[0]);
        r.green      = POS_W'(trk_pos[1]);
        r.blue       = POS_W'(trk_pos[2]);
        r.detent     = DET_W'(trk_pos[2] / 4);
        r.red_rise   = rise[2];
        r.green_rise = rise[1];
        r.blue_rise  = rise[0];
        r.all_rise   = (btn == ALL_DOWN) && (trk_buttons != ALL_DOWN);
        trk_buttons  = btn;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Clock, watchdog
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("** triple_knob_position_tracker: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Result side: random backpressure bursts, field-by-field check
    // ------------------------------------------------------------------
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (idle_on && $urandom_range(0, 7) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
                $display("mismatch %0s: expected %0d, got %0d", name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        t_knob_result got;
        t_knob_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_knob_result'(m_axis_tdata);
            if (predicted_readings.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("unexpected result beat: %h", m_axis_tdata);
            end else begin
                want = predicted_readings.pop_front();
                check_field("red_position",   want.red,        got.red);
                check_field("green_position", want.green,      got.green);
                check_field("blue_position",  want.blue,       got.blue);
                check_field("blue_detent",    want.detent,     got.detent);
                check_field("red_rise",       want.red_rise,   got.red_rise);
                check_field("green_rise",     want.green_rise, got.green_rise);
                check_field("blue_rise",      want.blue_rise,  got.blue_rise);
                check_field("all_rise",       want.all_rise,   got.all_rise);
                check_field("pad",            want.pad,        got.pad);
            end
        end
    end

    // ------------------------------------------------------------------
    // Sample side. Every task is entered and left just after a falling edge.
    // ------------------------------------------------------------------
    task automatic push_sample(input logic [SAMPLE_W-1:0] w);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 17);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w;
        do @(posedge i_clk); while (!s_axis_tready);
        predicted_readings.push_back(track_sample(w));
        for (int k = 0; k < 3; k++) sent_count[k] = w[lane_lsb(k) +: CNT_W];
        sent_buttons = w[BTN_LSB +: BTN_W];
        @(negedge i_clk);
    endtask

    // turn each knob by the given count change; spare high bits are random
    task automatic turn_knobs(input int dr, input int dg, input int db,
                              input logic [BTN_W-1:0] btn);
        logic [SAMPLE_W-1:0] w;
        w = $urandom;
        w[BTN_LSB +: BTN_W] = btn;
        w[RED_LSB +: CNT_W] = sent_count[0] + CNT_W'(dr);
        w[GRN_LSB +: CNT_W] = sent_count[1] + CNT_W'(dg);
        w[BLU_LSB +: CNT_W] = sent_count[2] + CNT_W'(db);
        push_sample(w);
    endtask

    // drop valid, let every result come back, then let the pipe settle
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (predicted_readings.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_NEGATE:   trk_negate   = data[0];
            CFG_ROTATION: trk_rotation = data[ROT_W-1:0];
            CFG_LOWER:    trk_lower    = data[LO_W-1:0];
            CFG_BLUE_MIN: trk_blue_min = data[BND_W-1:0];
            CFG_BLUE_MAX: trk_blue_max = data[BND_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // full register set, only once the block has gone quiet
    task automatic apply_settings(input logic [CFG_DATA_W-1:0] negate,
                                  input logic [CFG_DATA_W-1:0] rotation,
                                  input logic [CFG_DATA_W-1:0] lower,
                                  input logic [CFG_DATA_W-1:0] blue_min,
                                  input logic [CFG_DATA_W-1:0] blue_max);
        wait_drained();
        write_reg(CFG_NEGATE,   negate);
        write_reg(CFG_ROTATION, rotation);
        write_reg(CFG_LOWER,    lower);
        write_reg(CFG_BLUE_MIN, blue_min);
        write_reg(CFG_BLUE_MAX, blue_max);
        // unused slots must leave everything alone
        if ($urandom_range(0, 3) == 0)
            write_reg(CFG_IDX_W'(SPARE_IDX + $urandom_range(0, 2)), CFG_DATA_W'($urandom));
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // one random beat: mostly a biased turn, some full-range jumps and noise
    task automatic send_random_turn(input int trend, input int span);
        int               pick;
        int               lane;
        int               d [3];
        logic [BTN_W-1:0] btn;
        pick = $urandom_range(0, 15);
        if (pick == 0) begin
            push_sample($urandom);
        end else begin
            for (int k = 0; k < 3; k++) begin
                if (pick == 1)
                    d[k] = int'($urandom_range(0, 255)) - 128;
                else
                    d[k] = trend * int'($urandom_range(0, span))
                         + int'($urandom_range(0, 6)) - 3;
            end
            btn = sent_buttons;
            case ($urandom_range(0, 15))
                0, 1:       btn = ALL_DOWN;
                2:          btn = '0;
                3, 4, 5, 6: begin
                    lane = $urandom_range(0, BTN_W - 1);
                    btn[lane] = ~btn[lane];
                end
                default: ;
            endcase
            turn_knobs(d[0], d[1], d[2], btn);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // reset config: first sample, count extremes, wrap and clamp at defaults
    task automatic test_first_sample();
        turn_knobs(128, 127, 255, 3'b101);      // only recorded, rises vs zero
        turn_knobs(127, 127, 127, ALL_DOWN);    // largest step up, all-pressed edge
        turn_knobs(127, 127, 127, ALL_DOWN);    // held: no edges
        turn_knobs(-128, -128, -128, '0);       // half-turn reads as -128
        push_sample('1);
        push_sample('0);
        repeat (4) turn_knobs(100, 100, 100, 3'b010);  // red wraps, green/blue clamp
        repeat (3) turn_knobs(-128, -128, -128, 3'b100);
    endtask

    // bound corner cases that need config
    task automatic test_bound_cases();
        // zero span: red pinned to lower; blue can reach the most negative value
        apply_settings('0, '0, CFG_DATA_W'(-2048), CFG_DATA_W'(-4096), CFG_DATA_W'(4095));
        repeat (3) turn_knobs(-128, -128, -128, ALL_DOWN);
        // crossed bounds on green and blue, reversed direction
        apply_settings(1, 1, CFG_DATA_W'(2047), CFG_DATA_W'(100), CFG_DATA_W'(-100));
        turn_knobs(5, -7, 90, 3'b001);
        turn_knobs(-100, 100, -128, 3'b011);
        turn_knobs(0, 0, 0, ALL_DOWN);
        // red sits at 2047; one step down wraps to 6141, past the position range
        apply_settings('0, CFG_DATA_W'(4095), CFG_DATA_W'(2047),
                       CFG_DATA_W'(-2048), CFG_DATA_W'(4095));
        turn_knobs(-1, 127, 127, '0);
        repeat (2) turn_knobs(127, 127, 127, 3'b110);
    endtask

    // phases of random turns under changing config; phase 5 and the last two phases without idling
    task automatic test_random_sweep();
        logic [CFG_DATA_W-1:0] b_lo;
        logic [CFG_DATA_W-1:0] b_hi;
        logic [CFG_DATA_W-1:0] swap;
        int                    trend;
        int                    span;
        for (int ph = 0; ph < PHASES; ph++) begin
            idle_on = (ph < PHASES - 2) && (ph != 5);
            trend = int'($urandom_range(0, 2)) - 1;
            span  = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 12)
                                                 : $urandom_range(13, 127);
            case (ph)
                0: apply_settings('0, CFG_DATA_W'(256), '0, '0, CFG_DATA_W'(255));
                1: begin
                    // reversed knobs driven down: positions climb to the top
                    apply_settings(1, CFG_DATA_W'(4095), CFG_DATA_W'(2047),
                                   CFG_DATA_W'(-2048), CFG_DATA_W'(4095));
                    trend = -1;
                    span  = 127;
                end
                2: begin
                    apply_settings('0, '0, CFG_DATA_W'(-2048),
                                   CFG_DATA_W'(-4096), CFG_DATA_W'(4095));
                    trend = -1;
                    span  = 127;
                end
                3: apply_settings(1, 1, CFG_DATA_W'(2047), CFG_DATA_W'(100),
                                  CFG_DATA_W'(-100));
                default: begin
                    b_lo = CFG_DATA_W'($urandom);
                    b_hi = CFG_DATA_W'($urandom);
                    if ($urandom_range(0, 2) != 0 && $signed(b_lo) > $signed(b_hi)) begin
                        swap = b_lo;
                        b_lo = b_hi;
                        b_hi = swap;
                    end
                    apply_settings(CFG_DATA_W'($urandom),
                                   ($urandom_range(0, 1) == 0) ?
                                       CFG_DATA_W'($urandom_range(0, 15)) :
                                       CFG_DATA_W'($urandom),
                                   CFG_DATA_W'($urandom), b_lo, b_hi);
                end
            endcase
            repeat (PHASE_BEATS) send_random_turn(trend, span);
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_first_sample();
        test_bound_cases();
        test_random_sweep();
        wait_drained();

        if (mismatch_count == 0) begin
            $display("** triple_knob_position_tracker: PASSED **");
        end else begin
            $display("** triple_knob_position_tracker: FAILED **");
        end
        $finish;
    end

endmodule

`default_nettype wire
